FILE: hdl/cdeu_pkg.sv
package cdeu_pkg;

	localparam int NUM_STAGES = 6;

	localparam logic [13:0] YEAR_MAX    = 14'd9999;
	localparam logic [3:0]  MONTH_MAX   = 4'd12;
	localparam logic [3:0]  MONTH_FEB   = 4'd2;
	localparam logic [4:0]  HOUR_MAX    = 5'd23;
	localparam logic [5:0]  MINUTE_MAX  = 6'd59;
	localparam logic [5:0]  SECOND_MAX  = 6'd59;

	// x / 100 == (x * DIV100_MUL) >> DIV100_SHIFT for every 14-bit x
	localparam logic [12:0] DIV100_MUL   = 13'd5243;
	localparam int          DIV100_SHIFT = 19;

	localparam logic [16:0] SEC_PER_DAY  = 17'd86400;
	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
	localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
	localparam logic [19:0] US_PER_SEC   = 20'd1000000;
	localparam logic [9:0]  US_PER_MS    = 10'd1000;
	localparam logic [58:0] EPOCH_US     = 59'd62135596800000000;

	// upper bound allows for unchecked milliseconds up to 1023 on the last second
	localparam logic signed [58:0] EPOCH_US_MIN = -59'sd62135596800000000;
	localparam logic signed [58:0] EPOCH_US_MAX = 59'sd253402300800023000;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [9:0]  millisecond;
	} date_item_t;

	typedef struct packed {
		logic signed [58:0] epoch_us;
		logic               invalid;
	} result_item_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} pipe_ctl_t;

	// calendar half to scaling half
	typedef struct packed {
		logic [22:0] days;
		logic [16:0] tod_sec;
		logic [9:0]  millisecond;
		logic        bad;
	} cal_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// days before the first of the month, non-leap year
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] st;
		unique case (m)
			4'd1:    st = 9'd0;
			4'd2:    st = 9'd31;
			4'd3:    st = 9'd59;
			4'd4:    st = 9'd90;
			4'd5:    st = 9'd120;
			4'd6:    st = 9'd151;
			4'd7:    st = 9'd181;
			4'd8:    st = 9'd212;
			4'd9:    st = 9'd243;
			4'd10:   st = 9'd273;
			4'd11:   st = 9'd304;
			4'd12:   st = 9'd334;
			default: st = 9'd0;
		endcase
		return st;
	endfunction

endpackage

FILE: hdl/cdeu_ctrl.sv
module cdeu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	output logic                 result_valid,
	input  logic                 result_stall,
	output cdeu_pkg::pipe_ctl_t  ctl
);

	logic [cdeu_pkg::NUM_STAGES-1:0] valid_q;
	logic [cdeu_pkg::NUM_STAGES:0]   rdy;

	// a stage may load when it is empty or the one after it moves on
	always_comb begin
		rdy[cdeu_pkg::NUM_STAGES] = !result_stall;
		for (int k = cdeu_pkg::NUM_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (rdy[0]) begin
				valid_q[0] <= item_valid;
			end
			for (int k = 1; k < cdeu_pkg::NUM_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign ctl.load     = rdy[cdeu_pkg::NUM_STAGES-1:0];
	assign item_stall   = !rdy[0];
	assign result_valid = valid_q[cdeu_pkg::NUM_STAGES-1];

endmodule

FILE: hdl/cdeu_cal.sv
module cdeu_cal (
	input  logic                  clk,
	input  cdeu_pkg::pipe_ctl_t   ctl,
	input  cdeu_pkg::date_item_t  item,
	output cdeu_pkg::cal_t        cal
);

	// stage 1
	logic [13:0] year_s1, py_s1;
	logic [7:0]  q100y_s1, q100p_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [9:0]  ms_s1;
	logic [16:0] tod_sec_s1;
	logic        ym_bad_s1, tod_bad_s1;

	// stage 2
	logic        leap_s2;
	logic [22:0] days_year_s2;
	logic [3:0]  month_s2;
	logic [4:0]  day_s2;
	logic [9:0]  ms_s2;
	logic [16:0] tod_sec_s2;
	logic        bad_s2;

	// stage 3
	cdeu_pkg::cal_t cal_s3;

	logic [13:0] py;
	logic [26:0] prod_y, prod_p;
	logic [13:0] r100_full;
	logic [6:0]  r100;
	logic        leap;
	logic [22:0] days_year;
	logic [4:0]  mlen;
	logic        day_bad;
	logic [22:0] days;

	always_comb begin
		py     = item.year - 14'd1;
		prod_y = 27'(item.year) * 27'(cdeu_pkg::DIV100_MUL);
		prod_p = 27'(py) * 27'(cdeu_pkg::DIV100_MUL);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[0]) begin
			year_s1    <= item.year;
			py_s1      <= py;
			q100y_s1   <= prod_y[cdeu_pkg::DIV100_SHIFT +: 8];
			q100p_s1   <= prod_p[cdeu_pkg::DIV100_SHIFT +: 8];
			month_s1   <= item.month;
			day_s1     <= item.day_of_month;
			ms_s1      <= item.millisecond;
			tod_sec_s1 <= 17'(item.hour) * 17'(cdeu_pkg::SEC_PER_HOUR)
			            + 17'(item.minute) * 17'(cdeu_pkg::SEC_PER_MIN)
			            + 17'(item.second);
			ym_bad_s1  <= (item.year == 14'd0) || (item.year > cdeu_pkg::YEAR_MAX)
			            || (item.month == 4'd0) || (item.month > cdeu_pkg::MONTH_MAX);
			tod_bad_s1 <= (item.hour > cdeu_pkg::HOUR_MAX)
			            || (item.minute > cdeu_pkg::MINUTE_MAX)
			            || (item.second > cdeu_pkg::SECOND_MAX);
		end
	end

	// leap by 4/100/400; year % 400 == 0 is year % 100 == 0 with year / 100 % 4 == 0
	always_comb begin
		r100_full = year_s1 - 14'(q100y_s1) * 14'd100;
		r100      = r100_full[6:0];
		leap      = ((year_s1[1:0] == 2'd0) && (r100 != 7'd0))
		         || ((r100 == 7'd0) && (q100y_s1[1:0] == 2'd0));
		days_year = 23'(py_s1) * 23'd365 + 23'(py_s1[13:2])
		          - 23'(q100p_s1) + 23'(q100p_s1[7:2]);
	end

	always_ff @(posedge clk) begin
		if (ctl.load[1]) begin
			leap_s2      <= leap;
			days_year_s2 <= days_year;
			month_s2     <= month_s1;
			day_s2       <= day_s1;
			ms_s2        <= ms_s1;
			tod_sec_s2   <= tod_sec_s1;
			bad_s2       <= ym_bad_s1 || tod_bad_s1;
		end
	end

	always_comb begin
		mlen    = cdeu_pkg::month_len(month_s2)
		        + 5'((month_s2 == cdeu_pkg::MONTH_FEB) && leap_s2);
		day_bad = (day_s2 == 5'd0) || (day_s2 > mlen);
		days    = days_year_s2 + 23'(cdeu_pkg::month_start(month_s2))
		        + 23'((month_s2 > cdeu_pkg::MONTH_FEB) && leap_s2)
		        + 23'(day_s2) - 23'd1;
	end

	always_ff @(posedge clk) begin
		if (ctl.load[2]) begin
			cal_s3.days        <= days;
			cal_s3.tod_sec     <= tod_sec_s2;
			cal_s3.millisecond <= ms_s2;
			cal_s3.bad         <= bad_s2 || day_bad;
		end
	end

	assign cal = cal_s3;

endmodule

FILE: hdl/cdeu_scale.sv
module cdeu_scale (
	input  logic                    clk,
	input  cdeu_pkg::pipe_ctl_t     ctl,
	input  cdeu_pkg::cal_t          cal,
	output cdeu_pkg::result_item_t  result
);

	logic [39:0] sec_s4;
	logic [9:0]  ms_s4;
	logic        bad_s4;

	logic [39:0] p_lo_s5, p_hi_s5;
	logic [58:0] ms_off_s5;
	logic        bad_s5;

	cdeu_pkg::result_item_t result_s6;

	logic [58:0] total;

	always_ff @(posedge clk) begin
		if (ctl.load[3]) begin
			sec_s4 <= 40'(cal.days) * 40'(cdeu_pkg::SEC_PER_DAY) + 40'(cal.tod_sec);
			ms_s4  <= cal.millisecond;
			bad_s4 <= cal.bad;
		end
	end

	// seconds split in two 20-bit halves so each product stays 20 x 20
	always_ff @(posedge clk) begin
		if (ctl.load[4]) begin
			p_lo_s5   <= 40'(sec_s4[19:0]) * 40'(cdeu_pkg::US_PER_SEC);
			p_hi_s5   <= 40'(sec_s4[39:20]) * 40'(cdeu_pkg::US_PER_SEC);
			ms_off_s5 <= 59'(ms_s4) * 59'(cdeu_pkg::US_PER_MS) - cdeu_pkg::EPOCH_US;
			bad_s5    <= bad_s4;
		end
	end

	// result is taken modulo 2^59
	always_comb begin
		total = {p_hi_s5[38:0], 20'd0} + 59'(p_lo_s5) + ms_off_s5;
	end

	always_ff @(posedge clk) begin
		if (ctl.load[5]) begin
			result_s6.epoch_us <= bad_s5 ? '0 : $signed(total);
			result_s6.invalid  <= bad_s5;
		end
	end

	assign result = result_s6;

endmodule

FILE: hdl/civil_date_to_epoch_us_unit.sv
// Gregorian date and time of day to signed microseconds since 1970-01-01 00:00.
// One item per cycle at full rate while result_stall is low; each item passes
// through six register stages (three for the calendar check and day count,
// three for the scaling to microseconds, the last of which is the output
// register). A field out of range gives invalid = 1 and epoch_us = 0;
// milliseconds are not checked and are added as they stand. A stalled result
// holds the pipeline only as far back as the first empty stage.
module civil_date_to_epoch_us_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  cdeu_pkg::date_item_t    item,
	output logic                    result_valid,
	input  logic                    result_stall,
	output cdeu_pkg::result_item_t  result
);

	cdeu_pkg::pipe_ctl_t ctl;
	cdeu_pkg::cal_t      cal;

	cdeu_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.ctl          (ctl)
	);

	cdeu_cal u_cal (
		.clk  (clk),
		.ctl  (ctl),
		.item (item),
		.cal  (cal)
	);

	cdeu_scale u_scale (
		.clk    (clk),
		.ctl    (ctl),
		.cal    (cal),
		.result (result)
	);

	// input held back only when every stage is full and the output waits
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled with room in the pipeline");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.invalid) |-> (result.epoch_us == '0))
		else $error("invalid item with nonzero epoch");

	a_epoch_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.invalid) |->
			((result.epoch_us >= cdeu_pkg::EPOCH_US_MIN)
			&& (result.epoch_us <= cdeu_pkg::EPOCH_US_MAX)))
		else $error("epoch outside calendar range");

endmodule
